// File: sv/xie_pkg.sv
// ----------------------------------------------------------------------------
// xie_pkg: shared types, constants and form table of the instruction encoder
// Holds the request record, the per-mode form descriptor and its lookup.
// ----------------------------------------------------------------------------
package xie_pkg;

  localparam int unsigned MaxBytes  = 10;
  localparam int unsigned IdxW      = $clog2(MaxBytes);
  localparam int unsigned LenW      = $clog2(MaxBytes + 1);
  localparam int unsigned ModeCount = 70;

  localparam logic [7:0] RexBase  = 8'h40;
  localparam logic [7:0] RexB     = 8'h41;
  localparam logic [7:0] EscByte  = 8'h0F;
  localparam logic [7:0] SibByte  = 8'h24;
  localparam logic [7:0] PreNone  = 8'h00;
  localparam logic [7:0] PreLock  = 8'hF0;
  localparam logic [7:0] PreRep   = 8'hF3;
  localparam logic [7:0] PreRepne = 8'hF2;
  localparam logic [7:0] PreOpsz  = 8'h66;

  typedef logic [MaxBytes-1:0][7:0] code_t;
  typedef logic [LenW-1:0]          len_t;
  typedef logic [IdxW-1:0]          idx_t;

  typedef enum logic [3:0] {
    KIND_SHORT,
    KIND_RET,
    KIND_MOVI,
    KIND_RR_SD,
    KIND_RR_DS,
    KIND_RX,
    KIND_MEM_D,
    KIND_MEM_S,
    KIND_MEM_X
  } kind_e;

  typedef enum logic [2:0] {
    IMM_NONE,
    IMM_8,
    IMM_8M63,
    IMM_8M31,
    IMM_32,
    IMM_64
  } imm_e;

  typedef enum logic [1:0] {
    W_ZERO,
    W_ONE,
    W_INPUT
  } wsel_e;

  typedef struct packed {
    logic       known;
    kind_e      kind;
    logic [7:0] pre;
    wsel_e      wsel;
    logic       esc;
    logic [7:0] op;
    logic [2:0] ext;
    imm_e       imk;
    logic       addcc;
  } form_t;

  typedef struct packed {
    logic [6:0]        mode;
    logic [3:0]        dest_reg;
    logic [3:0]        src_reg;
    logic [3:0]        base_reg;
    logic signed [31:0] displacement;
    logic [63:0]       immediate;
    logic [3:0]        condition_code;
    logic              wide_operand;
  } req_t;

  typedef struct packed {
    logic busy;
    logic last_taken;
  } ser_status_t;

  function automatic form_t mk_form(input kind_e k, input logic [7:0] pre,
                                    input wsel_e ws, input logic esc,
                                    input logic [7:0] op, input logic [2:0] ext,
                                    input imm_e im, input logic addcc);
    form_t f;
    f.known = 1'b1;
    f.kind  = k;
    f.pre   = pre;
    f.wsel  = ws;
    f.esc   = esc;
    f.op    = op;
    f.ext   = ext;
    f.imk   = im;
    f.addcc = addcc;
    return f;
  endfunction

  function automatic form_t form_lookup(input logic [6:0] mode);
    form_t f;
    f = '0;
    case (mode)
      7'd0:  f = mk_form(KIND_SHORT, PreNone, W_ZERO, 1'b0, 8'h50, 3'd0, IMM_NONE, 1'b0);
      7'd1:  f = mk_form(KIND_SHORT, PreNone, W_ZERO, 1'b0, 8'h58, 3'd0, IMM_NONE, 1'b0);
      7'd2:  f = mk_form(KIND_RET,   PreNone, W_ZERO, 1'b0, 8'hC3, 3'd0, IMM_NONE, 1'b0);
      7'd3:  f = mk_form(KIND_RX,    PreNone, W_ZERO, 1'b0, 8'hFF, 3'd2, IMM_NONE, 1'b0);
      7'd4:  f = mk_form(KIND_MOVI,  PreNone, W_ONE,  1'b0, 8'hB8, 3'd0, IMM_64,   1'b0);
      7'd5:  f = mk_form(KIND_RR_SD, PreNone, W_ONE,  1'b0, 8'h89, 3'd0, IMM_NONE, 1'b0);
      7'd6:  f = mk_form(KIND_MEM_D, PreNone, W_ONE,  1'b0, 8'h8B, 3'd0, IMM_NONE, 1'b0);
      7'd7:  f = mk_form(KIND_MEM_S, PreNone, W_ONE,  1'b0, 8'h89, 3'd0, IMM_NONE, 1'b0);
      7'd8:  f = mk_form(KIND_RR_SD, PreNone, W_ONE,  1'b0, 8'h01, 3'd0, IMM_NONE, 1'b0);
      7'd9:  f = mk_form(KIND_RR_SD, PreNone, W_ONE,  1'b0, 8'h29, 3'd0, IMM_NONE, 1'b0);
      7'd10: f = mk_form(KIND_RR_SD, PreNone, W_ONE,  1'b0, 8'h21, 3'd0, IMM_NONE, 1'b0);
      7'd11: f = mk_form(KIND_RR_SD, PreNone, W_ONE,  1'b0, 8'h09, 3'd0, IMM_NONE, 1'b0);
      7'd12: f = mk_form(KIND_RR_SD, PreNone, W_ONE,  1'b0, 8'h31, 3'd0, IMM_NONE, 1'b0);
      7'd13: f = mk_form(KIND_RX,    PreNone, W_ONE,  1'b0, 8'h81, 3'd0, IMM_32,   1'b0);
      7'd14: f = mk_form(KIND_RX,    PreNone, W_ONE,  1'b0, 8'h81, 3'd5, IMM_32,   1'b0);
      7'd15: f = mk_form(KIND_MOVI,  PreNone, W_ZERO, 1'b0, 8'hB8, 3'd0, IMM_32,   1'b0);
      7'd16: f = mk_form(KIND_RR_SD, PreNone, W_ZERO, 1'b0, 8'h89, 3'd0, IMM_NONE, 1'b0);
      7'd17: f = mk_form(KIND_MEM_D, PreNone, W_ZERO, 1'b0, 8'h8B, 3'd0, IMM_NONE, 1'b0);
      7'd18: f = mk_form(KIND_MEM_S, PreNone, W_ZERO, 1'b0, 8'h89, 3'd0, IMM_NONE, 1'b0);
      7'd19: f = mk_form(KIND_MEM_D, PreNone, W_ONE,  1'b1, 8'hB6, 3'd0, IMM_NONE, 1'b0);
      7'd20: f = mk_form(KIND_RR_SD, PreNone, W_ZERO, 1'b0, 8'h21, 3'd0, IMM_NONE, 1'b0);
      7'd21: f = mk_form(KIND_RR_SD, PreNone, W_ZERO, 1'b0, 8'h09, 3'd0, IMM_NONE, 1'b0);
      7'd22: f = mk_form(KIND_RR_SD, PreNone, W_ZERO, 1'b0, 8'h31, 3'd0, IMM_NONE, 1'b0);
      7'd23: f = mk_form(KIND_RX,    PreNone, W_ZERO, 1'b0, 8'h81, 3'd6, IMM_32,   1'b0);
      7'd24: f = mk_form(KIND_RX,    PreNone, W_ONE,  1'b0, 8'hC1, 3'd4, IMM_8M63, 1'b0);
      7'd25: f = mk_form(KIND_RX,    PreNone, W_ONE,  1'b0, 8'hC1, 3'd5, IMM_8M63, 1'b0);
      7'd26: f = mk_form(KIND_RX,    PreNone, W_ONE,  1'b0, 8'hC1, 3'd7, IMM_8M63, 1'b0);
      7'd27: f = mk_form(KIND_RX,    PreNone, W_ONE,  1'b0, 8'hC1, 3'd1, IMM_8M63, 1'b0);
      7'd28: f = mk_form(KIND_RX,    PreNone, W_ZERO, 1'b0, 8'hC1, 3'd4, IMM_8M31, 1'b0);
      7'd29: f = mk_form(KIND_RX,    PreNone, W_ZERO, 1'b0, 8'hC1, 3'd5, IMM_8M31, 1'b0);
      7'd30: f = mk_form(KIND_RX,    PreNone, W_ZERO, 1'b0, 8'hC1, 3'd7, IMM_8M31, 1'b0);
      7'd31: f = mk_form(KIND_RX,    PreNone, W_ZERO, 1'b0, 8'hC1, 3'd1, IMM_8M31, 1'b0);
      7'd32: f = mk_form(KIND_MEM_X, PreNone, W_ZERO, 1'b1, 8'h90, 3'd0, IMM_NONE, 1'b1);
      7'd33: f = mk_form(KIND_RR_DS, PreNone, W_ONE,  1'b1, 8'h40, 3'd0, IMM_NONE, 1'b1);
      7'd34: f = mk_form(KIND_RR_DS, PreNone, W_ZERO, 1'b1, 8'h40, 3'd0, IMM_NONE, 1'b1);
      7'd35: f = mk_form(KIND_RX,    PreNone, W_ONE,  1'b0, 8'h83, 3'd7, IMM_8,    1'b0);
      7'd36: f = mk_form(KIND_MEM_D, PreRep,   W_ZERO, 1'b1, 8'h10, 3'd0, IMM_NONE, 1'b0);
      7'd37: f = mk_form(KIND_MEM_S, PreRep,   W_ZERO, 1'b1, 8'h11, 3'd0, IMM_NONE, 1'b0);
      7'd38: f = mk_form(KIND_MEM_D, PreRepne, W_ZERO, 1'b1, 8'h10, 3'd0, IMM_NONE, 1'b0);
      7'd39: f = mk_form(KIND_MEM_S, PreRepne, W_ZERO, 1'b1, 8'h11, 3'd0, IMM_NONE, 1'b0);
      7'd40: f = mk_form(KIND_MEM_D, PreOpsz,  W_ZERO, 1'b1, 8'h6F, 3'd0, IMM_NONE, 1'b0);
      7'd41: f = mk_form(KIND_MEM_S, PreOpsz,  W_ZERO, 1'b1, 8'h7F, 3'd0, IMM_NONE, 1'b0);
      7'd42: f = mk_form(KIND_RR_DS, PreRep,   W_ZERO, 1'b1, 8'h58, 3'd0, IMM_NONE, 1'b0);
      7'd43: f = mk_form(KIND_RR_DS, PreRep,   W_ZERO, 1'b1, 8'h5C, 3'd0, IMM_NONE, 1'b0);
      7'd44: f = mk_form(KIND_RR_DS, PreRep,   W_ZERO, 1'b1, 8'h59, 3'd0, IMM_NONE, 1'b0);
      7'd45: f = mk_form(KIND_RR_DS, PreRep,   W_ZERO, 1'b1, 8'h5E, 3'd0, IMM_NONE, 1'b0);
      7'd46: f = mk_form(KIND_RR_DS, PreRep,   W_ZERO, 1'b1, 8'h51, 3'd0, IMM_NONE, 1'b0);
      7'd47: f = mk_form(KIND_RR_DS, PreRepne, W_ZERO, 1'b1, 8'h58, 3'd0, IMM_NONE, 1'b0);
      7'd48: f = mk_form(KIND_RR_DS, PreRepne, W_ZERO, 1'b1, 8'h5C, 3'd0, IMM_NONE, 1'b0);
      7'd49: f = mk_form(KIND_RR_DS, PreRepne, W_ZERO, 1'b1, 8'h59, 3'd0, IMM_NONE, 1'b0);
      7'd50: f = mk_form(KIND_RR_DS, PreRepne, W_ZERO, 1'b1, 8'h5E, 3'd0, IMM_NONE, 1'b0);
      7'd51: f = mk_form(KIND_RR_DS, PreRepne, W_ZERO, 1'b1, 8'h51, 3'd0, IMM_NONE, 1'b0);
      7'd52: f = mk_form(KIND_RR_DS, PreNone,  W_ZERO, 1'b1, 8'h2E, 3'd0, IMM_NONE, 1'b0);
      7'd53: f = mk_form(KIND_RR_DS, PreOpsz,  W_ZERO, 1'b1, 8'h2E, 3'd0, IMM_NONE, 1'b0);
      7'd54: f = mk_form(KIND_RR_DS, PreNone,  W_ZERO, 1'b1, 8'h57, 3'd0, IMM_NONE, 1'b0);
      7'd55: f = mk_form(KIND_RR_DS, PreOpsz,  W_ZERO, 1'b1, 8'h57, 3'd0, IMM_NONE, 1'b0);
      7'd56: f = mk_form(KIND_RR_DS, PreNone,  W_ZERO, 1'b1, 8'h58, 3'd0, IMM_NONE, 1'b0);
      7'd57: f = mk_form(KIND_RR_DS, PreNone,  W_ZERO, 1'b1, 8'h5C, 3'd0, IMM_NONE, 1'b0);
      7'd58: f = mk_form(KIND_RR_DS, PreNone,  W_ZERO, 1'b1, 8'h59, 3'd0, IMM_NONE, 1'b0);
      7'd59: f = mk_form(KIND_RR_DS, PreNone,  W_ZERO, 1'b1, 8'h54, 3'd0, IMM_NONE, 1'b0);
      7'd60: f = mk_form(KIND_RR_DS, PreNone,  W_ZERO, 1'b1, 8'h56, 3'd0, IMM_NONE, 1'b0);
      7'd61: f = mk_form(KIND_RR_DS, PreRep,   W_INPUT, 1'b1, 8'h2A, 3'd0, IMM_NONE, 1'b0);
      7'd62: f = mk_form(KIND_RR_DS, PreRepne, W_INPUT, 1'b1, 8'h2A, 3'd0, IMM_NONE, 1'b0);
      7'd63: f = mk_form(KIND_RR_DS, PreRep,   W_INPUT, 1'b1, 8'h2C, 3'd0, IMM_NONE, 1'b0);
      7'd64: f = mk_form(KIND_RR_DS, PreRepne, W_INPUT, 1'b1, 8'h2C, 3'd0, IMM_NONE, 1'b0);
      7'd65: f = mk_form(KIND_RR_DS, PreRep,   W_ZERO, 1'b1, 8'h5A, 3'd0, IMM_NONE, 1'b0);
      7'd66: f = mk_form(KIND_RR_DS, PreRepne, W_ZERO, 1'b1, 8'h5A, 3'd0, IMM_NONE, 1'b0);
      7'd67: f = mk_form(KIND_MEM_S, PreLock,  W_INPUT, 1'b1, 8'hC1, 3'd0, IMM_NONE, 1'b0);
      7'd68: f = mk_form(KIND_MEM_S, PreLock,  W_INPUT, 1'b1, 8'hB1, 3'd0, IMM_NONE, 1'b0);
      7'd69: f = mk_form(KIND_MEM_S, PreNone,  W_INPUT, 1'b0, 8'h87, 3'd0, IMM_NONE, 1'b0);
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: sv/xie_req_if.sv
// ----------------------------------------------------------------------------
// xie_req_if: instruction request channel
// Valid/ready handshake carrying one instruction request per transaction.
// ----------------------------------------------------------------------------
interface xie_req_if;
  logic               valid;
  logic               ready;
  logic [6:0]         mode;
  logic [3:0]         dest_reg;
  logic [3:0]         src_reg;
  logic [3:0]         base_reg;
  logic signed [31:0] displacement;
  logic [63:0]        immediate;
  logic [3:0]         condition_code;
  logic               wide_operand;

  modport source (
    output valid, mode, dest_reg, src_reg, base_reg, displacement, immediate,
           condition_code, wide_operand,
    input  ready
  );

  modport sink (
    input  valid, mode, dest_reg, src_reg, base_reg, displacement, immediate,
           condition_code, wide_operand,
    output ready
  );
endinterface

// File: sv/xie_byte_if.sv
// ----------------------------------------------------------------------------
// xie_byte_if: machine-code byte channel
// Valid/ready handshake carrying one code byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface xie_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (
    output valid, code_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, code_byte, last_byte,
    output ready
  );
endinterface

// File: sv/xie_encoder.sv
// ----------------------------------------------------------------------------
// xie_encoder: combinational instruction encoder
// Turns one registered request into its byte string and byte count.
// ----------------------------------------------------------------------------
module xie_encoder (
  input  xie_pkg::req_t  req_i,
  output xie_pkg::code_t code_o,
  output xie_pkg::len_t  len_o
);

  xie_pkg::form_t form;

  assign form = xie_pkg::form_lookup(req_i.mode);

  always_comb begin
    logic [7:0]        op;
    logic              w;
    logic [3:0]        rg;
    logic [3:0]        rm;
    logic              mem;
    logic [63:0]       imm_v;
    logic [3:0]        imm_n;
    logic [31:0]       disp;
    xie_pkg::idx_t     pos;
    xie_pkg::code_t    code;

    code  = '0;
    pos   = '0;
    disp  = req_i.displacement;
    w     = (form.wsel == xie_pkg::W_INPUT) ? req_i.wide_operand
                                            : (form.wsel == xie_pkg::W_ONE);
    op    = form.op + (form.addcc ? {4'd0, req_i.condition_code} : 8'd0);

    case (form.kind)
      xie_pkg::KIND_RR_SD: begin rg = req_i.src_reg;  rm = req_i.dest_reg; mem = 1'b0; end
      xie_pkg::KIND_RR_DS: begin rg = req_i.dest_reg; rm = req_i.src_reg;  mem = 1'b0; end
      xie_pkg::KIND_RX:    begin rg = {1'b0, form.ext}; rm = req_i.dest_reg; mem = 1'b0; end
      xie_pkg::KIND_MEM_D: begin rg = req_i.dest_reg; rm = req_i.base_reg; mem = 1'b1; end
      xie_pkg::KIND_MEM_S: begin rg = req_i.src_reg;  rm = req_i.base_reg; mem = 1'b1; end
      default:             begin rg = {1'b0, form.ext}; rm = req_i.base_reg; mem = 1'b1; end
    endcase

    case (form.imk)
      xie_pkg::IMM_8:    begin imm_v = {56'd0, req_i.immediate[7:0]};       imm_n = 4'd1; end
      xie_pkg::IMM_8M63: begin imm_v = {58'd0, req_i.immediate[5:0]};       imm_n = 4'd1; end
      xie_pkg::IMM_8M31: begin imm_v = {59'd0, req_i.immediate[4:0]};       imm_n = 4'd1; end
      xie_pkg::IMM_32:   begin imm_v = {32'd0, req_i.immediate[31:0]};      imm_n = 4'd4; end
      xie_pkg::IMM_64:   begin imm_v = req_i.immediate;                     imm_n = 4'd8; end
      default:           begin imm_v = '0;                                  imm_n = 4'd0; end
    endcase

    if (form.known) begin
      case (form.kind)
        xie_pkg::KIND_RET: begin
          code[pos] = op;
          pos = pos + 1'b1;
        end
        xie_pkg::KIND_SHORT: begin
          if (req_i.dest_reg[3]) begin
            code[pos] = xie_pkg::RexB;
            pos = pos + 1'b1;
          end
          code[pos] = op + {5'd0, req_i.dest_reg[2:0]};
          pos = pos + 1'b1;
        end
        xie_pkg::KIND_MOVI: begin
          code[pos] = xie_pkg::RexBase | {4'd0, w, 2'd0, req_i.dest_reg[3]};
          pos = pos + 1'b1;
          code[pos] = op + {5'd0, req_i.dest_reg[2:0]};
          pos = pos + 1'b1;
        end
        default: begin
          if (form.pre != xie_pkg::PreNone) begin
            code[pos] = form.pre;
            pos = pos + 1'b1;
          end
          code[pos] = xie_pkg::RexBase | {4'd0, w, rg[3], 1'b0, rm[3]};
          pos = pos + 1'b1;
          if (form.esc) begin
            code[pos] = xie_pkg::EscByte;
            pos = pos + 1'b1;
          end
          code[pos] = op;
          pos = pos + 1'b1;
          code[pos] = {1'b1, ~mem, rg[2:0], rm[2:0]};
          pos = pos + 1'b1;
          if (mem) begin
            if (rm[2:0] == 3'd4) begin
              code[pos] = xie_pkg::SibByte;
              pos = pos + 1'b1;
            end
            for (int i = 0; i < 4; i++) begin
              code[pos] = disp[8*i +: 8];
              pos = pos + 1'b1;
            end
          end
        end
      endcase

      for (int i = 0; i < 8; i++) begin
        if (4'(i) < imm_n) begin
          code[pos] = imm_v[8*i +: 8];
          pos = pos + 1'b1;
        end
      end
    end

    code_o = code;
    len_o  = xie_pkg::len_t'(pos);
  end

endmodule

// File: sv/xie_serializer.sv
// ----------------------------------------------------------------------------
// xie_serializer: byte output buffer
// Holds one encoded instruction and hands it out one byte per transaction.
// ----------------------------------------------------------------------------
module xie_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  xie_pkg::code_t       code_i,
  input  xie_pkg::len_t        len_i,
  output xie_pkg::ser_status_t status_o,
  xie_byte_if.source           code_o
);

  logic           valid_q, valid_d;
  xie_pkg::idx_t  idx_q, idx_d;
  xie_pkg::code_t code_q;
  xie_pkg::len_t  len_q;
  logic           last;
  logic           taken;

  assign last  = (xie_pkg::len_t'(idx_q) == len_q - 1'b1);
  assign taken = valid_q && code_o.ready;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (taken) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_q <= code_i;
      len_q  <= len_i;
    end
  end

  assign code_o.valid     = valid_q;
  assign code_o.code_byte = code_q[idx_q];
  assign code_o.last_byte = last;

  assign status_o.busy       = valid_q;
  assign status_o.last_taken = taken && last;

endmodule

// File: sv/x86_64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder: x86-64 machine-code byte generator
// Encodes one instruction request into its byte string, one byte per output.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one instruction request per transaction (mode, registers,
//            displacement, immediate, condition code, width flag).
//   code_o : the encoded bytes, one per transaction, last_byte set on the
//            final byte of each instruction. Modes 70..127 emit nothing.
// Path: a request is held in the request register, encoded, and loaded into
//   the byte buffer, which then offers its first byte.
// Buffer: an instruction of N bytes (1..10) holds the byte buffer until its
//   last byte leaves; requests that emit nothing pass without loading it.
// The request register takes a new request while the buffer still drains the
//   previous one, so the next encoding loads right after the last byte leaves.
// Stall: when code_o.ready is low the current byte holds, the buffer and the
//   request register fill, and req_i.ready drops.
// Reset: rst_ni clears the request and buffer valid flags; nothing else is
//   stored across instructions.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  xie_req_if.sink    req_i,
  xie_byte_if.source code_o
);

  logic                 in_valid_q, in_valid_d;
  xie_pkg::req_t        in_q;
  xie_pkg::code_t       enc_code;
  xie_pkg::len_t        enc_len;
  xie_pkg::ser_status_t ser_status;
  logic                 consume;
  logic                 load;
  logic                 req_take;

  assign consume  = in_valid_q &&
                    ((enc_len == '0) || !ser_status.busy || ser_status.last_taken);
  assign load     = consume && (enc_len != '0);
  assign req_i.ready = !in_valid_q || consume;
  assign req_take = req_i.valid && req_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (req_take) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_q.mode           <= req_i.mode;
      in_q.dest_reg       <= req_i.dest_reg;
      in_q.src_reg        <= req_i.src_reg;
      in_q.base_reg       <= req_i.base_reg;
      in_q.displacement   <= req_i.displacement;
      in_q.immediate      <= req_i.immediate;
      in_q.condition_code <= req_i.condition_code;
      in_q.wide_operand   <= req_i.wide_operand;
    end
  end

  xie_encoder u_encoder (
    .req_i  (in_q),
    .code_o (enc_code),
    .len_o  (enc_len)
  );

  xie_serializer u_serializer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .code_i   (enc_code),
    .len_i    (enc_len),
    .status_o (ser_status),
    .code_o   (code_o)
  );

  a_load_free_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!ser_status.busy || ser_status.last_taken))
    else $error("buffer loaded while still holding bytes");

  a_more_bytes_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_o.valid && code_o.ready && !code_o.last_byte) |=> code_o.valid)
    else $error("instruction ended without a last byte");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_o.valid && code_o.ready && code_o.last_byte && !load) |=> !code_o.valid)
    else $error("byte offered after final byte with nothing loaded");

  a_request_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take |=> in_valid_q)
    else $error("accepted request not held");

endmodule
